// ===== hw/rtl/vb_pkg.sv =====
// Shared constants and types of the 2x2x2 volume binning block.
`timescale 1ns / 1ps
package vb_pkg;

    // Voxel and volume limits
    localparam int PIXEL_BITS = 16;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_DEPTH  = 1024;

    // Raster counter widths
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PLANE_W = $clog2(MAX_DEPTH);

    // Cube sum store: one entry per (y/2, x/2) cube position
    localparam int ADDR_W = (ROW_W - 1) + (COL_W - 1);
    localparam int PAIR_W = PIXEL_BITS + 1;
    localparam int SUM_W  = PIXEL_BITS + 3;

    // Configuration register widths and indexes
    localparam int WX_W       = 10;
    localparam int HY_W       = 10;
    localparam int DZ_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_Z  = 2'd2;

    // Read-modify-write request for one voxel pair
    typedef struct packed {
        logic                  valid;
        logic [ADDR_W-1:0]     addr;
        logic [PAIR_W-1:0]     pair;
        logic                  first;
        logic                  last;
        logic                  done;
    } t_rmw_req;

    // One finished cube average
    typedef struct packed {
        logic                  valid;
        logic [PIXEL_BITS-1:0] value;
        logic                  done;
    } t_bin_res;

endpackage

// ===== hw/rtl/vb_ctrl.sv =====
// Raster position counters, configuration registers and pair request decode.
`timescale 1ns / 1ps
module vb_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                           i_accept,
    input  logic [vb_pkg::PIXEL_BITS-1:0]  i_voxel,
    output vb_pkg::t_rmw_req               o_req
);
    import vb_pkg::*;

    logic [WX_W-1:0]    r_width_x;
    logic [HY_W-1:0]    r_height_y;
    logic [DZ_W-1:0]    r_depth_z;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [PLANE_W-1:0] r_plane;
    logic [PIXEL_BITS-1:0] r_pair_hold;

    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [PLANE_W-1:0] n_plane;

    logic [WX_W-1:0] w_eff;
    logic [HY_W-1:0] h_eff;
    logic [DZ_W-1:0] d_eff;
    logic [WX_W-1:0] ew;
    logic [HY_W-1:0] eh;
    logic [DZ_W-1:0] ed;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [PLANE_W:0] plane_inc;
    logic in_range;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_x  <= WX_W'(MAX_WIDTH);
            r_height_y <= HY_W'(MAX_HEIGHT);
            r_depth_z  <= DZ_W'(MAX_DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH_X:  r_width_x  <= i_cfg_data[WX_W-1:0];
                CFG_HEIGHT_Y: r_height_y <= i_cfg_data[HY_W-1:0];
                CFG_DEPTH_Z:  r_depth_z  <= i_cfg_data[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp extents to the legal range, then round down to even
    always_comb begin
        w_eff = r_width_x;
        if (r_width_x < WX_W'(2))               w_eff = WX_W'(2);
        else if (r_width_x > WX_W'(MAX_WIDTH))  w_eff = WX_W'(MAX_WIDTH);
        h_eff = r_height_y;
        if (r_height_y < HY_W'(2))              h_eff = HY_W'(2);
        else if (r_height_y > HY_W'(MAX_HEIGHT)) h_eff = HY_W'(MAX_HEIGHT);
        d_eff = r_depth_z;
        if (r_depth_z < DZ_W'(2))               d_eff = DZ_W'(2);
        else if (r_depth_z > DZ_W'(MAX_DEPTH))  d_eff = DZ_W'(MAX_DEPTH);
        ew = {w_eff[WX_W-1:1], 1'b0};
        eh = {h_eff[HY_W-1:1], 1'b0};
        ed = {d_eff[DZ_W-1:1], 1'b0};
    end

    // Next raster position, wrapping against the current extents
    always_comb begin
        col_inc   = {1'b0, r_col} + 1'b1;
        row_inc   = {1'b0, r_row} + 1'b1;
        plane_inc = {1'b0, r_plane} + 1'b1;
        n_col   = col_inc[COL_W-1:0];
        n_row   = r_row;
        n_plane = r_plane;
        if (WX_W'(col_inc) >= w_eff) begin
            n_col = '0;
            n_row = row_inc[ROW_W-1:0];
            if (HY_W'(row_inc) >= h_eff) begin
                n_row   = '0;
                n_plane = plane_inc[PLANE_W-1:0];
                if (DZ_W'(plane_inc) >= d_eff) begin
                    n_plane = '0;
                end
            end
        end
    end

    // Position counters and even-column hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_plane     <= '0;
            r_pair_hold <= '0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
            if (in_range && !r_col[0]) begin
                r_pair_hold <= i_voxel;
            end
        end
    end

    // Request decode: an odd column inside the even extents adds a pair
    always_comb begin
        in_range    = (WX_W'(r_col) < ew) && (HY_W'(r_row) < eh) && (DZ_W'(r_plane) < ed);
        o_req.valid = i_accept && in_range && r_col[0];
        o_req.addr  = {r_row[ROW_W-1:1], r_col[COL_W-1:1]};
        o_req.pair  = PAIR_W'(r_pair_hold) + PAIR_W'(i_voxel);
        o_req.first = !r_row[0] && !r_plane[0];
        o_req.last  = r_row[0] && r_plane[0];
        o_req.done  = (WX_W'(r_col) == ew - WX_W'(1))
                   && (HY_W'(r_row) == eh - HY_W'(1))
                   && (DZ_W'(r_plane) == ed - DZ_W'(1));
    end

    // A pair request only ever comes from an odd column
    a_req_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.valid |-> r_col[0])
        else $error("pair request on even column");

    // Column counter advances by one or wraps on every accepted voxel
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_col == '0) || (r_col == $past(r_col) + 1'b1))
        else $error("column counter skipped");

endmodule

// ===== hw/rtl/vb_sum.sv =====
// Cube partial sum store with a registered read-modify-write.
`timescale 1ns / 1ps
module vb_sum (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vb_pkg::t_rmw_req i_req,
    output logic             o_pending,
    output vb_pkg::t_bin_res o_res
);
    import vb_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [SUM_W-1:0] mem [DEPTH];
    t_rmw_req         r_req;
    logic [SUM_W-1:0] r_rd_data;
    logic [SUM_W-1:0] sum;

    // Request stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req.valid <= i_req.valid;
        end
        r_req.addr  <= i_req.addr;
        r_req.pair  <= i_req.pair;
        r_req.first <= i_req.first;
        r_req.last  <= i_req.last;
        r_req.done  <= i_req.done;
    end

    // New sum: the first pair of a cube overwrites the entry
    always_comb begin
        sum = r_req.first ? SUM_W'(r_req.pair) : r_rd_data + SUM_W'(r_req.pair);
    end

    // Store: read for the incoming pair, write back the finished one
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_rd_data <= mem[i_req.addr];
        end
        if (r_req.valid) begin
            mem[r_req.addr] <= sum;
        end
    end

    assign o_pending   = r_req.valid && r_req.last;
    assign o_res.valid = r_req.valid && r_req.last;
    assign o_res.value = sum[SUM_W-1:3];
    assign o_res.done  = r_req.done;

    // Back-to-back pair requests never hit the same entry, so no forwarding
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && r_req.valid) |-> (i_req.addr != r_req.addr))
        else $error("read and write of the same cube entry overlap");

    // Two pair requests never follow in consecutive cycles
    a_no_consec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |=> !i_req.valid)
        else $error("pair requests in consecutive cycles");

endmodule

// ===== hw/rtl/vb_ofifo.sv =====
// Two-entry output queue that decouples the store from the result channel.
`timescale 1ns / 1ps
module vb_ofifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vb_pkg::t_bin_res              i_res,
    output logic [1:0]                    o_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vb_pkg::PIXEL_BITS-1:0] o_value,
    output logic                          o_done
);
    import vb_pkg::*;

    logic [PIXEL_BITS-1:0] r_value [2];
    logic                  r_done  [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_count;
    logic                  pop;

    assign pop = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_res.valid) r_wp <= !r_wp;
            if (pop)         r_rp <= !r_rp;
            r_count <= r_count + {1'b0, i_res.valid} - {1'b0, pop};
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_value[r_wp] <= i_res.value;
            r_done[r_wp]  <= i_res.done;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_value = r_value[r_rp];
    assign o_done  = r_done[r_rp];

    // Upstream flow control must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !(i_res.valid && !pop))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

endmodule

// ===== hw/rtl/volume_bin_2x2x2_average_top.sv =====
// Top level of the 2x2x2 box-average volume downsampler.
//
// Voxels (16-bit unsigned) arrive on the s_axis channel in raster order,
// x fastest, then y, then z. Each 2x2x2 cube of the volume yields one
// result on m_axis: tdata carries the truncated mean of its eight voxels,
// tlast marks the last cube of the volume. Odd trailing columns, rows and
// planes are consumed and dropped. Extents are written through i_cfg_we /
// i_cfg_index / i_cfg_data (0: width_x, 1: height_y, 2: depth_z); the user
// must do so only while the block is idle, which the block does not enforce.
// One voxel is taken per cycle while s_axis tready is high. A result reaches
// m_axis via the store stage register and the result queue. Partial sums live
// in a 65536 x 19-bit synchronous store, read for each pair and written back
// in the next cycle. A two-entry result queue lets input continue while a
// result waits; when the receiver stalls, s_axis tready drops once the queue
// holds two results, or one while another is still in the store stage.
// Synchronous reset returns the counters to the start of a volume and the
// extents to 512 x 512 x 1024; the store needs no clearing, since the first
// pair of each cube overwrites its entry.
`timescale 1ns / 1ps
module volume_bin_2x2x2_average_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [vb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Voxel input
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [15:0]                    i_s_axis_tdata,  // [15:0] voxel_value
    // Binned output
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [15:0]                    o_m_axis_tdata,  // [15:0] binned_value
    output logic                           o_m_axis_tlast   // volume_done
);
    import vb_pkg::*;

    t_rmw_req   req;
    t_bin_res   res;
    logic       pending;
    logic [1:0] q_count;
    logic       accept;

    // Accept only when the queue can absorb any result still in flight
    assign o_s_axis_tready = (q_count == 2'd0) || ((q_count == 2'd1) && !pending);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    vb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_voxel     (i_s_axis_tdata[PIXEL_BITS-1:0]),
        .o_req       (req)
    );

    vb_sum u_sum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_pending (pending),
        .o_res     (res)
    );

    vb_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_count (q_count),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (o_m_axis_tdata),
        .o_done  (o_m_axis_tlast)
    );

    // Input stalls only when the result queue is at risk
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (q_count != 2'd0))
        else $error("input stalled with empty result queue");

    // Queue never holds a result without presenting it
    a_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid == (q_count != 2'd0))
        else $error("output valid disagrees with queue fill");

endmodule
